FILE: design/ftq_pkg.sv
// Shared types and constants of the fixed-timeout timer queue
`timescale 1ns / 1ps

package ftq_pkg;

    localparam int SLOTS   = 32;
    localparam int ID_W    = 5;
    localparam int TIME_W  = 48;
    localparam int DUE_W   = TIME_W + 1;
    localparam int DIFF_W  = TIME_W + 2;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(64'd1000000000);

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_REARM  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        RES_FIRED  = 2'd0,
        RES_ACCEPT = 2'd1,
        RES_REJECT = 2'd2,
        RES_WAIT   = 2'd3
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_QUEUED    = 2'd1,
        ST_FIRED     = 2'd2,
        ST_CANCELLED = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_APPEND,
        S_TSUM,
        S_TCHK
    } fsm_state_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] qtime;
    } ftq_entry_t;

    typedef struct packed {
        logic shift;
        logic append;
    } ftq_cell_ctrl_t;

    typedef struct packed {
        logic              pop;
        logic              remove;
        logic              append;
        logic [ID_W-1:0]   key;
        logic [ID_W-1:0]   new_id;
        logic [TIME_W-1:0] new_time;
    } ftq_chain_cmd_t;

endpackage

FILE: design/fixed_timeout_timer_queue.sv
// Top level of the fixed-timeout timer queue: control, slot states, result register
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one word: func, entry_id, now_time.
//   func selects tick, add, cancel or re-arm. now_time must not decrease.
//   Output channel (out_valid/out_ready) carries result words: result_code,
//   fired_entry, next_wait and last; last marks the final word of a request.
//   Add, cancel and a rejected request give one word from S_LOOK and free the
//   input when that word is written; a re-arm holds the input in S_APPEND
//   while it moves the entry to the back.
//   A tick handles fired entries one by one: the head time is summed with the
//   timeout in S_TSUM and compared with now_time in S_TCHK. The wait report
//   comes from S_TCHK when the head has not expired, or from S_TSUM when the
//   queue is empty. A new word is taken only when the previous one is done.
//   cfg_wr_en/cfg_wr_data write timeout_reg; write only while idle.
//   Reset empties the queue, marks all slots idle and loads the default timeout.
//   A stalled receiver holds the result register; each result word waits until it drains.

module fixed_timeout_timer_queue
    import ftq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [ID_W-1:0]   entry_id,
    input  logic [TIME_W-1:0] now_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_code,
    output logic [ID_W-1:0]   fired_entry,
    output logic [TIME_W-1:0] next_wait,
    output logic              last,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data
);

    fsm_state_t        state_reg;
    fsm_state_t        state_next;
    func_t             func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [DUE_W-1:0]  due_reg;
    slot_state_t       slot_state_reg [SLOTS];

    logic              out_valid_reg;
    result_t           out_code_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TIME_W-1:0] out_wait_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              out_free;
    logic              id_ok;
    logic              look_queued;
    logic              look_ok;
    logic [DIFF_W-1:0] diff;
    logic              expired;
    logic [TIME_W-1:0] wait_sat;
    logic [TIME_W-1:0] empty_wait;

    logic              emit;
    result_t           emit_code;
    logic [ID_W-1:0]   emit_id;
    logic [TIME_W-1:0] emit_wait;
    logic              emit_last;
    logic              slot_we;
    logic [ID_W-1:0]   slot_wr_idx;
    slot_state_t       slot_wr_val;
    ftq_chain_cmd_t    cmd;
    ftq_entry_t        head;

    ftq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign id_ok       = (int'(id_reg) < SLOTS);
    assign look_queued = id_ok && (slot_state_reg[id_reg] == ST_QUEUED);
    assign look_ok     = (func_reg == FUNC_ADD) ? (id_ok && !look_queued) : look_queued;
    assign diff        = {1'b0, due_reg} - {2'b00, now_reg};
    assign expired     = diff[DIFF_W-1] || (diff == '0);
    assign wait_sat    = diff[TIME_W] ? '1 : diff[TIME_W-1:0];
    assign empty_wait  = (timeout_reg == '0) ? TIME_W'(1) : timeout_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (func_t'(func) == FUNC_TICK) ? S_TSUM : S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    state_next = (look_ok && func_reg == FUNC_REARM) ? S_APPEND : S_IDLE;
                end
            end
            S_APPEND:
            begin
                state_next = S_IDLE;
            end
            S_TSUM:
            begin
                if (head.valid)
                begin
                    state_next = S_TCHK;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TCHK:
            begin
                if (out_free)
                begin
                    state_next = expired ? S_TSUM : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit         = 1'b0;
        emit_code    = RES_REJECT;
        emit_id      = id_reg;
        emit_wait    = '0;
        emit_last    = 1'b1;
        slot_we      = 1'b0;
        slot_wr_idx  = id_reg;
        slot_wr_val  = ST_QUEUED;
        cmd          = '0;
        cmd.key      = id_reg;
        cmd.new_id   = id_reg;
        cmd.new_time = now_reg;
        unique case (state_reg)
            S_LOOK:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_code = look_ok ? RES_ACCEPT : RES_REJECT;
                    if (look_ok)
                    begin
                        unique case (func_reg)
                            FUNC_ADD:
                            begin
                                cmd.append  = 1'b1;
                                slot_we     = 1'b1;
                                slot_wr_val = ST_QUEUED;
                            end
                            FUNC_CANCEL:
                            begin
                                cmd.remove  = 1'b1;
                                slot_we     = 1'b1;
                                slot_wr_val = ST_CANCELLED;
                            end
                            FUNC_REARM:
                            begin
                                cmd.remove  = 1'b1;
                            end
                            default:
                            begin
                                cmd.remove  = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
            end
            S_TSUM:
            begin
                if (!head.valid && out_free)
                begin
                    emit      = 1'b1;
                    emit_code = RES_WAIT;
                    emit_id   = '0;
                    emit_wait = empty_wait;
                end
            end
            S_TCHK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (expired)
                    begin
                        emit_code   = RES_FIRED;
                        emit_id     = head.id;
                        emit_last   = 1'b0;
                        cmd.pop     = 1'b1;
                        slot_we     = 1'b1;
                        slot_wr_idx = head.id;
                        slot_wr_val = ST_FIRED;
                    end
                    else
                    begin
                        emit_code = RES_WAIT;
                        emit_id   = '0;
                        emit_wait = wait_sat;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_state_reg[k] <= ST_IDLE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (slot_we)
            begin
                slot_state_reg[slot_wr_idx] <= slot_wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func_t'(func);
            id_reg   <= entry_id;
            now_reg  <= now_time;
        end
        if (state_reg == S_TSUM)
        begin
            due_reg <= {1'b0, head.qtime} + {1'b0, timeout_reg};
        end
        if (emit)
        begin
            out_code_reg <= emit_code;
            out_id_reg   <= emit_id;
            out_wait_reg <= emit_wait;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_code = out_code_reg;
    assign fired_entry = out_id_reg;
    assign next_wait   = out_wait_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while full");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_check_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCHK) |-> ($past(state_reg) == S_TSUM || $past(state_reg) == S_TCHK))
        else $error("expiry check without due time");
`endif

endmodule

FILE: design/ftq_cell.sv
// One queue position: holds an entry, takes its right neighbor on shift
`timescale 1ns / 1ps

module ftq_cell
    import ftq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ftq_cell_ctrl_t    ctrl,
    input  logic [ID_W-1:0]   key,
    input  logic              left_valid,
    input  ftq_entry_t        right,
    input  logic [ID_W-1:0]   new_id,
    input  logic [TIME_W-1:0] new_time,
    output ftq_entry_t        entry,
    output logic              match
);

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        if (ctrl.shift)
        begin
            valid_next = right.valid;
            id_next    = right.id;
            time_next  = right.qtime;
        end
        else if (ctrl.append && !valid_reg && left_valid)
        begin
            valid_next = 1'b1;
            id_next    = new_id;
            time_next  = new_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign entry.valid = valid_reg;
    assign entry.id    = id_reg;
    assign entry.qtime = time_reg;
    assign match       = valid_reg && (id_reg == key);

endmodule

FILE: design/ftq_chain.sv
// Row of queue cells, head at position zero, with shift and append control
`timescale 1ns / 1ps

module ftq_chain
    import ftq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ftq_chain_cmd_t cmd,
    output ftq_entry_t     head
);

    ftq_entry_t     entry_arr [SLOTS];
    ftq_entry_t     right_arr [SLOTS];
    ftq_cell_ctrl_t ctrl_arr  [SLOTS];
    logic           left_arr  [SLOTS];
    logic [SLOTS-1:0] valid_vec;
    logic [SLOTS-1:0] match_vec;
    logic [SLOTS-1:0] shift_vec;

    always_comb
    begin
        if (cmd.pop)
        begin
            shift_vec = '1;
        end
        else if (cmd.remove)
        begin
            shift_vec = ~(match_vec - SLOTS'(1));
        end
        else
        begin
            shift_vec = '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_cell
            assign valid_vec[i]         = entry_arr[i].valid;
            assign ctrl_arr[i].shift    = shift_vec[i];
            assign ctrl_arr[i].append   = cmd.append;

            if (i == 0)
            begin : g_first
                assign left_arr[i] = 1'b1;
            end
            else
            begin : g_inner
                assign left_arr[i] = entry_arr[i-1].valid;
            end

            if (i == SLOTS - 1)
            begin : g_last
                assign right_arr[i] = '0;
            end
            else
            begin : g_mid
                assign right_arr[i] = entry_arr[i+1];
            end

            ftq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl_arr[i]),
                .key        (cmd.key),
                .left_valid (left_arr[i]),
                .right      (right_arr[i]),
                .new_id     (cmd.new_id),
                .new_time   (cmd.new_time),
                .entry      (entry_arr[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    assign head = entry_arr[0];

`ifndef SYNTHESIS
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + (SLOTS+1)'(1)))
        else $error("queue cells not packed toward head");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pop, cmd.remove, cmd.append}))
        else $error("more than one chain command");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> $onehot(match_vec))
        else $error("removed entry not found exactly once");
`endif

endmodule
